// ----- rtl/tskpq_pkg.sv -----
// Shared types and constants for the two-key sorted priority queue.
package tskpq_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);

   localparam int ROAD_W  = 8;
   localparam int KEY_W   = 16;
   localparam int CNT_OUT_W = 5;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic [ROAD_W-1:0] road;
      logic [KEY_W-1:0]  density;
      logic [KEY_W-1:0]  wait_time;
   } entry_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic      push;
      logic      pop;
      entry_type item;
   } cell_cmd_type;

   // what a cell shows its neighbors
   typedef struct packed {
      entry_type item;
      logic      valid;
      logic      ins;
   } cell_link_type;

   typedef struct packed {
      entry_type item;
      logic      valid;
   } cell_next_type;

endpackage

// ----- rtl/two_key_sorted_priority_queue_unit.sv -----
// Top level of the two-key sorted priority queue.
//
// Usage:
//   req channel: one beat is a push (req_tuser = 0) of an entry given in
//   req_tdata, or a pop of the head (req_tuser = 1, req_tdata ignored).
//   rsp channel: one beat per request with the head, the entry count and
//   the empty and dropped flags after that operation.
//   Entries stay ordered by density, then wait time, both larger first;
//   equal keys keep arrival order. A push to a full queue is dropped and
//   flagged; a pop on an empty queue changes nothing.
// Timing:
//   The response is registered and shows in the cycle after the request beat.
//   One request per cycle is taken while the response register is free or
//   being drained: every cell of the chain compares the new key and shifts
//   in the same cycle, so the cell compare and the one-slot shift set the rate.
// Reset clears all cell valid bits and the count; the queue starts empty.
// A stalled response holds its register; a new request is taken only in a
// cycle where that register is free or being drained.
module two_key_sorted_priority_queue_unit
   import tskpq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // road_id[7:0], density[23:8], wait_time[39:24]
   input  logic        req_tuser,  // func: 0 push, 1 pop
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata   // head_road[7:0], head_density[23:8],
                                   // head_wait[39:24], entry_count[44:40],
                                   // queue_empty[45], push_dropped[46], zero[47]
);

   logic               rsp_valid_ff, rsp_valid_in;
   logic [47:0]        rsp_data_ff, rsp_data_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic          accept;
   logic          full;
   logic          dropped;
   cell_cmd_type  cmd;
   cell_link_type links [CAPACITY];
   cell_link_type left_bound, right_bound;
   cell_next_type head_next;
   entry_type     head;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == COUNT_W'(CAPACITY));

   assign cmd.item.road      = req_tdata[7:0];
   assign cmd.item.density   = req_tdata[23:8];
   assign cmd.item.wait_time = req_tdata[39:24];
   assign cmd.push = accept && (req_tuser == FUNC_PUSH) && !full;
   assign cmd.pop  = accept && (req_tuser == FUNC_POP);
   assign dropped  = accept && (req_tuser == FUNC_PUSH) && full;

   assign left_bound.item  = '0;
   assign left_bound.valid = 1'b1;
   assign left_bound.ins   = 1'b0;
   assign right_bound.item  = '0;
   assign right_bound.valid = 1'b0;
   assign right_bound.ins   = 1'b1;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      if (i == 0) begin : g_head
         tskpq_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .cmd_i   (cmd),
            .left_i  (left_bound),
            .right_i (links[1]),
            .state_o (links[0]),
            .next_o  (head_next)
         );
      end else if (i == CAPACITY - 1) begin : g_tail
         tskpq_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .cmd_i   (cmd),
            .left_i  (links[i-1]),
            .right_i (right_bound),
            .state_o (links[i]),
            .next_o  ()
         );
      end else begin : g_mid
         tskpq_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .cmd_i   (cmd),
            .left_i  (links[i-1]),
            .right_i (links[i+1]),
            .state_o (links[i]),
            .next_o  ()
         );
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.pop && (count_ff != '0)) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   // empty queue reports a zero head
   assign head = head_next.valid ? head_next.item : '0;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, dropped, (count_in == '0), CNT_OUT_W'(count_in),
                         head.wait_time, head.density, head.road};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/tskpq_cell.sv -----
// One slot of the sorted chain: holds an entry and shifts with its neighbors.
module tskpq_cell
   import tskpq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_cmd_type  cmd_i,
   input  cell_link_type left_i,
   input  cell_link_type right_i,
   output cell_link_type state_o,
   output cell_next_type next_o
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      outranked;
   logic      ins;

   // new key strictly ahead of the held one
   assign outranked = (cmd_i.item.density > entry_ff.density) ||
                      ((cmd_i.item.density == entry_ff.density) &&
                       (cmd_i.item.wait_time > entry_ff.wait_time));
   assign ins = !valid_ff || outranked;

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd_i.push) begin
         if (ins && !left_i.ins) begin
            entry_in = cmd_i.item;
            valid_in = 1'b1;
         end else if (ins) begin
            // insertion point lies to the left: shift right
            entry_in = left_i.item;
            valid_in = left_i.valid;
         end
      end else if (cmd_i.pop) begin
         entry_in = right_i.item;
         valid_in = right_i.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign state_o.item  = entry_ff;
   assign state_o.valid = valid_ff;
   assign state_o.ins   = ins;
   assign next_o.item   = entry_in;
   assign next_o.valid  = valid_in;

endmodule

// ----- rtl/tskpq_checker.sv -----
// Port-level checks for the priority queue top level, bound to it.
module tskpq_checker
   import tskpq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // every request beat yields a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> rsp_tvalid)
      else $error("no response after request beat");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

   // empty queue reports a zero head and a zero count
   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[45]) |-> (rsp_tdata[39:0] == '0 && rsp_tdata[44:40] == '0))
      else $error("empty queue with nonzero head");

   // a dropped push only happens on a full, nonempty queue
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[46]) |->
         (!rsp_tdata[45] && rsp_tdata[44:40] == CNT_OUT_W'(CAPACITY)))
      else $error("push dropped while not full");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind two_key_sorted_priority_queue_unit tskpq_checker u_tskpq_checker (.*);
